// ===== rtl/e2q_pkg.sv =====
// Package for the Euler-to-quaternion block: fixed-point widths, CORDIC constants
// and the arctangent table. No dependencies.
`default_nettype none
package e2q_pkg;
  localparam int AngleW = 16;
  localparam int QuatW = 16;
  localparam int CordW = 34;
  localparam int TrigW = 17;
  localparam int AtanLen = 30;
  localparam logic signed [CordW-1:0] HalfPi = 34'sd1686629713;
  localparam logic signed [CordW-1:0] PiQ30 = 34'sd3373259426;

  typedef struct packed {
    logic signed [TrigW-1:0] c;
    logic signed [TrigW-1:0] s;
  } trig_t;

  function automatic logic signed [CordW-1:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 34'sd843314856;
      5'd1: atan_q30 = 34'sd497837829;
      5'd2: atan_q30 = 34'sd263043836;
      5'd3: atan_q30 = 34'sd133525158;
      5'd4: atan_q30 = 34'sd67021686;
      5'd5: atan_q30 = 34'sd33543515;
      5'd6: atan_q30 = 34'sd16775850;
      5'd7: atan_q30 = 34'sd8388437;
      5'd8: atan_q30 = 34'sd4194282;
      5'd9: atan_q30 = 34'sd2097149;
      5'd10: atan_q30 = 34'sd1048575;
      5'd11: atan_q30 = 34'sd524287;
      5'd12: atan_q30 = 34'sd262143;
      5'd13: atan_q30 = 34'sd131071;
      5'd14: atan_q30 = 34'sd65535;
      5'd15: atan_q30 = 34'sd32767;
      5'd16: atan_q30 = 34'sd16383;
      5'd17: atan_q30 = 34'sd8191;
      5'd18: atan_q30 = 34'sd4095;
      5'd19: atan_q30 = 34'sd2047;
      5'd20: atan_q30 = 34'sd1023;
      5'd21: atan_q30 = 34'sd511;
      5'd22: atan_q30 = 34'sd255;
      5'd23: atan_q30 = 34'sd127;
      5'd24: atan_q30 = 34'sd63;
      5'd25: atan_q30 = 34'sd31;
      5'd26: atan_q30 = 34'sd15;
      5'd27: atan_q30 = 34'sd7;
      5'd28: atan_q30 = 34'sd3;
      5'd29: atan_q30 = 34'sd1;
      default: atan_q30 = '0;
    endcase
  endfunction

  // Shift-and-subtract quotient of two non-negative values, for constants only.
  function automatic longint udiv(input longint a, input longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int k = 62; k >= 0; k--) begin
      r = (r << 1) | ((a >>> k) & 64'sd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'sd1 << k);
      end
    end
    return q;
  endfunction

  // CORDIC gain for n steps, evaluated at elaboration only.
  function automatic longint cordic_gain(input int n);
    longint v;
    longint r;
    longint b;
    longint m;
    v = 64'sd1 << 30;
    for (int i = 0; i < n && i < AtanLen; i++) begin
      v = v - udiv(v, (64'sd1 << (2 * i)) + 1);
    end
    m = v << 30;
    r = 0;
    b = 64'sd1 << 62;
    while (b > m) b = b >> 2;
    while (b != 0) begin
      if (m >= r + b) begin
        m = m - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/e2q_if.sv =====
// Valid/ready channel interfaces for the Euler-to-quaternion block.
// Depends on nothing.
`default_nettype none
interface e2q_angle_if;
  logic valid;
  logic ready;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] roll_angle;
  logic signed [15:0] yaw_angle;
  modport source (output valid, pitch_angle, roll_angle, yaw_angle, input ready);
  modport sink (input valid, pitch_angle, roll_angle, yaw_angle, output ready);
endinterface

interface e2q_quat_if;
  logic valid;
  logic ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface
`default_nettype wire

// ===== rtl/euler_to_quaternion.sv =====
// Top level: Euler angles (Q2.13) to unit quaternion (Q1.14), fully pipelined.
// Depends on e2q_pkg, e2q_if, e2q_cordic.
//
//  channel   dir   fields                                   format
//  ang       in    pitch_angle, roll_angle, yaw_angle       Q2.13 signed
//  quat      out   quat_w, quat_x, quat_y, quat_z           Q1.14 signed
//
// One word enters per cycle when not stalled. The pipeline has one fold
// stage, one CORDIC stage per step, one rounding stage, then two product stages,
// a sum stage and a saturation/output stage. The whole pipeline advances only
// when its last stage is empty or taken, so a stall freezes every word in place
// and loses or repeats nothing. Synchronous reset clears all valid bits and holds
// the input not ready.
`default_nettype none
module euler_to_quaternion #(
  parameter int CORDIC_STEPS = 16
) (
  input wire logic clk,
  input wire logic rst,
  e2q_angle_if.sink ang,
  e2q_quat_if.source quat
);
  import e2q_pkg::*;
  localparam int N = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;
  localparam int TrigLat = N + 2;
  localparam int Lat = TrigLat + 4;

  logic [Lat-1:0] vld;
  logic adv;
  trig_t tp, tr, ty;

  // Advance whenever the output register is free or being emptied.
  assign adv = !vld[Lat-1] || quat.ready;
  assign ang.ready = adv && !rst;
  assign quat.valid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Lat-2:0], ang.valid};
    end
  end

  e2q_cordic #(.Steps(CORDIC_STEPS)) u_pitch (
    .clk(clk), .en(adv), .angle(ang.pitch_angle), .trig(tp));
  e2q_cordic #(.Steps(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(adv), .angle(ang.roll_angle), .trig(tr));
  e2q_cordic #(.Steps(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(adv), .angle(ang.yaw_angle), .trig(ty));

  // First products: yaw times roll (Q30), pitch delayed alongside.
  logic signed [33:0] ccr, csr, scr, ssr;
  trig_t tp1;
  always_ff @(posedge clk) begin
    if (adv) begin
      ccr <= 34'(ty.c) * 34'(tr.c);
      csr <= 34'(ty.c) * 34'(tr.s);
      scr <= 34'(ty.s) * 34'(tr.c);
      ssr <= 34'(ty.s) * 34'(tr.s);
      tp1 <= tp;
    end
  end

  // Second products: times pitch, exact Q45.
  logic signed [50:0] p_ccc, p_sss, p_csc, p_scs, p_ccs, p_ssc, p_scc, p_css;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_ccc <= 51'(ccr) * 51'(tp1.c);
      p_sss <= 51'(ssr) * 51'(tp1.s);
      p_csc <= 51'(csr) * 51'(tp1.c);
      p_scs <= 51'(scr) * 51'(tp1.s);
      p_ccs <= 51'(ccr) * 51'(tp1.s);
      p_ssc <= 51'(ssr) * 51'(tp1.c);
      p_scc <= 51'(scr) * 51'(tp1.c);
      p_css <= 51'(csr) * 51'(tp1.s);
    end
  end

  // Sums with rounding offset, then shift to Q14.
  logic signed [51:0] sw, sx, sy, sz;
  localparam logic signed [51:0] RndQ45 = 52'sd1 << 30;
  always_ff @(posedge clk) begin
    if (adv) begin
      sw <= 52'(p_ccc) + 52'(p_sss) + RndQ45;
      sx <= 52'(p_csc) - 52'(p_scs) + RndQ45;
      sy <= 52'(p_ccs) + 52'(p_ssc) + RndQ45;
      sz <= 52'(p_scc) - 52'(p_css) + RndQ45;
    end
  end

  function automatic logic signed [QuatW-1:0] sat(input logic signed [51:0] v);
    logic signed [20:0] q;
    q = 21'(v >>> 31);
    if (q > 21'sd16384) sat = 16'sd16384;
    else if (q < -21'sd16384) sat = -16'sd16384;
    else sat = QuatW'(q);
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      quat.quat_w <= sat(sw);
      quat.quat_x <= sat(sx);
      quat.quat_y <= sat(sy);
      quat.quat_z <= sat(sz);
    end
  end

  a_ready_tracks_out: assert property (@(posedge clk) disable iff (rst)
    ang.ready == (!quat.valid || quat.ready))
    else $error("input ready does not follow output stage");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (vld[Lat-1] && !quat.ready) |=> vld[Lat-1] && $stable(quat.quat_w))
    else $error("output word changed during stall");
  a_in_flows: assert property (@(posedge clk) disable iff (rst)
    (ang.valid && ang.ready) |=> vld[0])
    else $error("accepted word not captured");
  a_range: assert property (@(posedge clk) disable iff (rst)
    quat.valid |-> (quat.quat_w <= 16'sd16384 && quat.quat_w >= -16'sd16384))
    else $error("quat_w out of range");
endmodule
`default_nettype wire

// ===== rtl/e2q_cordic.sv =====
// Pipelined rotation-mode CORDIC giving cosine and sine of half a Q2.13 angle.
// Depends on e2q_pkg.
`default_nettype none
module e2q_cordic #(
  parameter int Steps = 16
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [e2q_pkg::AngleW-1:0] angle,
  output e2q_pkg::trig_t trig
);
  import e2q_pkg::*;
  localparam int N = (Steps < AtanLen) ? Steps : AtanLen;
  localparam logic signed [CordW-1:0] Gain = CordW'(cordic_gain(Steps));

  logic signed [CordW-1:0] xs [N+1];
  logic signed [CordW-1:0] ys [N+1];
  logic signed [CordW-1:0] zs [N+1];
  logic neg [N+1];
  logic signed [CordW-1:0] z0;
  logic signed [CordW-1:0] xr;
  logic signed [CordW-1:0] yr;

  assign z0 = {{(CordW-AngleW-16){angle[AngleW-1]}}, angle, 16'd0};

  // Stage 0: fold the half angle into plus or minus pi/2.
  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= Gain;
      ys[0] <= '0;
      if (z0 > HalfPi) begin
        zs[0] <= z0 - PiQ30;
        neg[0] <= 1'b1;
      end else if (z0 < -HalfPi) begin
        zs[0] <= z0 + PiQ30;
        neg[0] <= 1'b1;
      end else begin
        zs[0] <= z0;
        neg[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        neg[i+1] <= neg[i];
        if (!zs[i][CordW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_q30(5'(i));
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_q30(5'(i));
        end
      end
    end
  end

  assign xr = (neg[N] ? -xs[N] : xs[N]) + CordW'(16384);
  assign yr = (neg[N] ? -ys[N] : ys[N]) + CordW'(16384);

  always_ff @(posedge clk) begin
    if (en) begin
      trig.c <= TrigW'(xr >>> 15);
      trig.s <= TrigW'(yr >>> 15);
    end
  end
endmodule
`default_nettype wire
